>>> hw/rtl/blm_pkg.sv
// Shared types, widths and constants of the battery level monitor.
package blm_pkg;

    // Field and register widths.
    localparam int PIN_W      = 12;
    localparam int SAMPLE_W   = 13;
    localparam int PCT_W      = 7;
    localparam int OFFSET_W   = 11;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 32;

    // Default averaging window and the largest clamped sample.
    localparam int WINDOW_DEF     = 20;
    localparam int SAMPLE_MAX_VAL = 8191;

    // Percent divider widths: numerator is (average - empty) * 100.
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(SAMPLE_MAX_VAL);
    localparam logic [PCT_W-1:0]    PCT_ZERO   = '0;
    localparam logic [PCT_W-1:0]    PCT_FULL   = PCT_W'(100);
    localparam logic [PCT_W-1:0]    PCT_STEP   = PCT_W'(1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMPTY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER = 3'd4;

    // Register reset values.
    localparam logic [OFFSET_W-1:0] OFFSET_RST  = '0;
    localparam logic [SAMPLE_W-1:0] EMPTY_RST   = 13'd3000;
    localparam logic [SAMPLE_W-1:0] FULL_RST    = 13'd4200;
    localparam logic [SAMPLE_W-1:0] LOW_RST     = 13'd3000;
    localparam logic [SAMPLE_W-1:0] RECOVER_RST = 13'd3200;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_MAP,
        ST_DIV,
        ST_OUT
    } t_state;

    // How the current sample relates to the filling of the window.
    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_FIRST,
        MODE_RUN
    } t_mode;

endpackage

>>> hw/rtl/battery_level_monitor_top.sv
// Battery level monitor: sample window, moving average, percent and low flag.
//
// Input stream (s_axis): one converter pin reading per transaction. The
// reading is doubled, offset, clamped to 0..8191 and shifted into a chain of
// WINDOW sample cells; a running sum follows the chain.
// Output stream (m_axis): one result transaction per input transaction with
// the average, the gated charge percent and the low-battery flags.
// Configuration: plain write port, one register per index; the user must
// write it only when idle, as the block does not enforce it. Timing: an input
// transaction is taken only in the idle state. Every sample passes the states
// MUL, FIX and MAP, then DIV when the window is full and the average lies
// strictly between the empty and full points, where the serial percent
// divider runs and hands over the quotient, and last OUT, which loads the
// result register. The next input transaction is taken only once the
// sequencer is back in idle. The average uses a reciprocal multiply and one
// correction step. The result register parts the two sides: the next input
// is taken while a result still waits, and the sequencer holds in its last
// state while the receiver stalls with a result already pending.
// Reset clears the window fill count, the sum, held percent, low state and
// the configuration registers to their defaults; the cells need no clearing.
module battery_level_monitor_top #(
    parameter int WINDOW = blm_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: pin_mv[11:0], zero padding above
    input  logic [blm_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: average_mv[12:0], charge_percent[19:13], low_battery[20],
    // entered_low[21], left_low[22], update_display[23], primed[24], zeros above
    output logic [blm_pkg::M_DATA_W-1:0]  o_m_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic                          i_cfg_we,
    input  logic [blm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [blm_pkg::CFG_W-1:0]     i_cfg_data
);
    import blm_pkg::*;

    localparam int SUM_W  = $clog2(SAMPLE_MAX_VAL * WINDOW + 1);
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int PROD_W = 2 * SUM_W;
    localparam logic [SUM_W-1:0]  RECIP     = SUM_W'((2 ** SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0]  WIN_SUM   = SUM_W'(WINDOW);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW - 1);
    localparam int PAD_W = M_DATA_W - SAMPLE_W - PCT_W - 5;

    // Configuration registers.
    logic [OFFSET_W-1:0] r_offset;
    logic [SAMPLE_W-1:0] r_empty;
    logic [SAMPLE_W-1:0] r_full;
    logic [SAMPLE_W-1:0] r_low_mv;
    logic [SAMPLE_W-1:0] r_recover;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= OFFSET_RST;
            r_empty   <= EMPTY_RST;
            r_full    <= FULL_RST;
            r_low_mv  <= LOW_RST;
            r_recover <= RECOVER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OFFSET:  r_offset  <= i_cfg_data[OFFSET_W-1:0];
                CFG_EMPTY:   r_empty   <= i_cfg_data;
                CFG_FULL:    r_full    <= i_cfg_data;
                CFG_LOW:     r_low_mv  <= i_cfg_data;
                CFG_RECOVER: r_recover <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and pipeline registers.
    t_state              r_state;
    t_state              n_state;
    t_mode               r_mode;
    logic [SUM_W-1:0]    r_sum;
    logic [FILL_W-1:0]   r_fill;
    logic [PROD_W-1:0]   r_prod;
    logic [SAMPLE_W-1:0] r_avg;
    logic [PCT_W-1:0]    r_pct;
    logic [PCT_W-1:0]    r_held;
    logic                r_low;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic w_s_acc;
    logic w_out_free;
    logic w_load;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_load          = (r_state == ST_OUT) && w_out_free;

    // Sample conditioning: double, add signed offset, clamp to 0..8191.
    logic signed [15:0]  w_raw;
    logic [SAMPLE_W-1:0] w_sample;

    assign w_raw = $signed({3'b000, i_s_axis_tdata[PIN_W-1:0], 1'b0})
                 + 16'($signed(r_offset));

    always_comb begin
        if (w_raw < 0) begin
            w_sample = '0;
        end else if (w_raw > $signed(16'(SAMPLE_MAX_VAL))) begin
            w_sample = SAMPLE_MAX;
        end else begin
            w_sample = w_raw[SAMPLE_W-1:0];
        end
    end

    // Sample chain: the last cell holds the sample that leaves the window.
    logic [SAMPLE_W-1:0] w_tap [0:WINDOW];

    assign w_tap[0] = w_sample;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        blm_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(w_s_acc),
            .i_data (w_tap[g]),
            .o_data (w_tap[g+1])
        );
    end

    // Running sum and fill count, updated on the input transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_fill <= '0;
        end else if (w_s_acc) begin
            if (r_fill == FILL_FULL) begin
                r_sum <= r_sum - SUM_W'(w_tap[WINDOW]) + SUM_W'(w_sample);
            end else begin
                r_sum  <= r_sum + SUM_W'(w_sample);
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // Average by reciprocal: the estimate is exact or one low.
    logic [SAMPLE_W-1:0] w_qest;
    logic [SUM_W-1:0]    w_rem;

    assign w_qest = r_prod[SUM_W +: SAMPLE_W];
    assign w_rem  = r_sum - SUM_W'(SUM_W'(w_qest) * WIN_SUM);

    // Percent divider start and operands.
    logic                 w_div_start;
    logic                 w_div_busy;
    logic [PCT_W-1:0]     w_div_quot;
    logic [DIV_NUM_W-1:0] w_div_num;
    logic [DIV_DEN_W-1:0] w_div_den;

    assign w_div_start = (r_state == ST_MAP) && (r_mode != MODE_FILL)
                       && (r_avg > r_empty) && (r_avg < r_full);
    assign w_div_num   = DIV_NUM_W'(DIV_NUM_W'(r_avg - r_empty) * DIV_NUM_W'(PCT_FULL));
    assign w_div_den   = r_full - r_empty;

    blm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_div_num),
        .i_den  (w_div_den),
        .o_busy (w_div_busy),
        .o_quot (w_div_quot)
    );

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    if (r_fill == FILL_FULL) begin
                        r_mode <= MODE_RUN;
                    end else if (r_fill == FILL_LAST) begin
                        r_mode <= MODE_FIRST;
                    end else begin
                        r_mode <= MODE_FILL;
                    end
                end
            end
            ST_MUL: r_prod <= PROD_W'(r_sum) * PROD_W'(RECIP);
            ST_FIX: begin
                if (w_rem >= WIN_SUM) begin
                    r_avg <= w_qest + 1'b1;
                end else begin
                    r_avg <= w_qest;
                end
            end
            ST_MAP: begin
                if (r_avg <= r_empty) begin
                    r_pct <= PCT_ZERO;
                end else if (r_avg >= r_full) begin
                    r_pct <= PCT_FULL;
                end
            end
            ST_DIV: begin
                if (!w_div_busy) begin
                    r_pct <= w_div_quot;
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    // Result: percent gating and low-state hysteresis.
    logic [SAMPLE_W-1:0] w_avg_out;
    logic [PCT_W-1:0]    n_held;
    logic                n_low;
    logic                w_entered;
    logic                w_left;
    logic                w_upd;
    logic                w_primed;
    logic [PCT_W-1:0]    w_diff;
    logic                w_enter_low;

    always_comb begin
        w_avg_out = '0;
        n_held    = r_held;
        n_low     = r_low;
        w_entered = 1'b0;
        w_left    = 1'b0;
        w_upd     = 1'b0;
        w_primed  = 1'b0;
        w_diff    = (r_pct > r_held) ? (r_pct - r_held) : (r_held - r_pct);
        w_enter_low = (r_avg <= r_low_mv);
        case (r_mode)
            MODE_FIRST: begin
                w_avg_out = r_avg;
                w_primed  = 1'b1;
                w_upd     = 1'b1;
                n_held    = r_pct;
                if (w_enter_low) begin
                    n_low     = 1'b1;
                    w_entered = 1'b1;
                end
            end
            MODE_RUN: begin
                w_avg_out = r_avg;
                w_primed  = 1'b1;
                if ((w_diff > PCT_STEP) || ((r_pct == PCT_ZERO) && (r_held != PCT_ZERO))
                        || ((r_pct == PCT_FULL) && (r_held != PCT_FULL))) begin
                    n_held = r_pct;
                    w_upd  = 1'b1;
                end
                if (!n_low && w_enter_low) begin
                    n_low     = 1'b1;
                    w_entered = 1'b1;
                    w_upd     = 1'b1;
                end
                if (n_low && (r_avg > r_recover)) begin
                    n_low  = 1'b0;
                    w_left = 1'b1;
                    w_upd  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Held state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= PCT_ZERO;
            r_low       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_held      <= n_held;
            r_low       <= n_low;
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {{PAD_W{1'b0}}, w_primed, w_upd, w_left, w_entered,
                           n_low, n_held, w_avg_out};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_FIX;
            ST_FIX: n_state = ST_MAP;
            ST_MAP: n_state = w_div_start ? ST_DIV : ST_OUT;
            ST_DIV: begin
                if (!w_div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/blm_cell.sv
// One sample cell of the window shift chain.
module blm_cell (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic [blm_pkg::SAMPLE_W-1:0] i_data,
    output logic [blm_pkg::SAMPLE_W-1:0] o_data
);
    import blm_pkg::*;

    logic [SAMPLE_W-1:0] r_data;

    // Take the neighbour's sample whenever a new sample enters the chain.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

>>> hw/rtl/blm_div.sv
// Serial restoring divider for the charge percent, one quotient bit per cycle.
module blm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [blm_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [blm_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_busy,
    output logic [blm_pkg::PCT_W-1:0]     o_quot
);
    import blm_pkg::*;

    localparam int CNT_W = $clog2(PCT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PCT_W - 1);

    logic                 r_busy;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_dsh;
    logic [PCT_W-1:0]     r_quot;
    logic                 w_fit;

    // The quotient is known to stay below 128, so the divisor starts shifted by six.
    assign w_fit = (r_rem >= r_dsh);

    // Control: busy from the start until the last quotient bit is done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == CNT_LAST) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: trial subtraction and quotient shift.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= DIV_NUM_W'(i_den) << (PCT_W - 1);
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_quot <= {r_quot[PCT_W-2:0], w_fit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

>>> tb/tb.sv
// Self-checking testbench for the battery level monitor top level.
`timescale 1ns / 1ps

module tb;
    import blm_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 3;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int NUM_PHASES   = 15;
    localparam int PHASE_ITEMS  = 40;
    localparam int PIN_MAX      = (1 << PIN_W) - 1;
    localparam int CFG_MAX      = (1 << CFG_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Tracks the expected window, percent and low state, and checks each report.
    class battery_scoreboard;
        typedef struct {
            logic [SAMPLE_W-1:0] average_mv;
            logic [PCT_W-1:0]    charge_percent;
            logic                low_battery;
            logic                entered_low;
            logic                left_low;
            logic                update_display;
            logic                primed;
        } t_report;

        logic signed [OFFSET_W-1:0] offset_mv;
        logic [SAMPLE_W-1:0]        empty_mv, full_mv, low_mv, recover_mv;
        logic [SAMPLE_W-1:0]        ring [WINDOW_DEF];
        int                         sum, wr_idx, fill, held_pct;
        bit                         low_st;
        t_report                    pending_reports[$];
        int errors, readings, reports, entries, exits, redraws, clamped;

        function new();
            offset_mv  = OFFSET_RST;
            empty_mv   = EMPTY_RST;
            full_mv    = FULL_RST;
            low_mv     = LOW_RST;
            recover_mv = RECOVER_RST;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_OFFSET:  offset_mv  = data[OFFSET_W-1:0];
                CFG_EMPTY:   empty_mv   = data;
                CFG_FULL:    full_mv    = data;
                CFG_LOW:     low_mv     = data;
                CFG_RECOVER: recover_mv = data;
                default: ;
            endcase
        endfunction

        // Maps an average onto 0..100 without dividing when the span is empty.
        function int to_percent(int avg);
            int e, f;
            e = int'(empty_mv);
            f = int'(full_mv);
            if (avg <= e) return 0;
            if (avg >= f) return 100;
            return ((avg - e) * 100) / (f - e);
        endfunction

        // Doubles the pin reading, adds the offset and clamps to the sample range.
        function int make_sample(logic [PIN_W-1:0] pin);
            int v;
            v = 2 * int'(pin) + int'(offset_mv);
            if (v < 0 || v > SAMPLE_MAX_VAL) clamped++;
            if (v < 0) v = 0;
            if (v > SAMPLE_MAX_VAL) v = SAMPLE_MAX_VAL;
            return v;
        endfunction

        // Advances the window by one accepted reading and queues the expected report.
        function void note_reading(logic [PIN_W-1:0] pin);
            t_report r;
            int      s, idx, avg, pct, diff;
            s   = make_sample(pin);
            r   = '{default: '0};
            avg = 0;
            idx = wr_idx;
            readings++;
            if (fill < WINDOW_DEF) begin
                ring[idx] = SAMPLE_W'(s);
                sum += s;
                fill++;
                wr_idx = (idx + 1) % WINDOW_DEF;
                if (fill == WINDOW_DEF) begin
                    // The sample that completes the window sets percent and low directly.
                    r.primed = 1'b1;
                    avg      = sum / WINDOW_DEF;
                    held_pct = to_percent(avg);
                    if (avg <= int'(low_mv)) begin
                        low_st        = 1'b1;
                        r.entered_low = 1'b1;
                    end
                    r.update_display = 1'b1;
                end
            end else begin
                r.primed  = 1'b1;
                sum       = sum - int'(ring[idx]) + s;
                ring[idx] = SAMPLE_W'(s);
                wr_idx    = (idx + 1) % WINDOW_DEF;
                avg       = sum / WINDOW_DEF;
                pct       = to_percent(avg);
                diff      = (pct > held_pct) ? pct - held_pct : held_pct - pct;
                if (diff > 1 || (pct == 0 && held_pct != 0) ||
                    (pct == 100 && held_pct != 100)) begin
                    held_pct         = pct;
                    r.update_display = 1'b1;
                end
                // Entry is tested before recovery, so both can fire on one sample.
                if (!low_st && avg <= int'(low_mv)) begin
                    low_st           = 1'b1;
                    r.entered_low    = 1'b1;
                    r.update_display = 1'b1;
                end
                if (low_st && avg > int'(recover_mv)) begin
                    low_st           = 1'b0;
                    r.left_low       = 1'b1;
                    r.update_display = 1'b1;
                end
            end
            r.average_mv     = avg[SAMPLE_W-1:0];
            r.charge_percent = held_pct[PCT_W-1:0];
            r.low_battery    = low_st;
            entries += r.entered_low;
            exits   += r.left_low;
            redraws += r.update_display;
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            end
        endfunction

        // Compares one output transaction with the oldest expected report.
        function void check_report(logic [M_DATA_W-1:0] word);
            t_report e;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual 0x%08h", $time, word);
                return;
            end
            e = pending_reports.pop_front();
            reports++;
            compare_field("average_mv", e.average_mv, word[12:0]);
            compare_field("charge_percent", e.charge_percent, word[19:13]);
            compare_field("low_battery", e.low_battery, word[20]);
            compare_field("entered_low", e.entered_low, word[21]);
            compare_field("left_low", e.left_low, word[22]);
            compare_field("update_display", e.update_display, word[23]);
            compare_field("primed", e.primed, word[24]);
            compare_field("padding", 0, word[M_DATA_W-1:25]);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [S_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [M_DATA_W-1:0]  o_m_axis_tdata;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    battery_scoreboard tracker;
    bit                quiet = 1'b0;
    int                rx_stall = 0;
    int                idle_cycles = 0;
    int                cfg_writes = 0;

    battery_level_monitor_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, none at all while quiet.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: checks each result transaction and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            tracker.check_report(o_m_axis_tdata);
        end
        if (rx_stall > 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall        <= rx_stall - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            rx_stall        <= pick_gap();
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one reading and returns at the edge where it is taken; valid stays high.
    task automatic send_reading(int pin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_DATA_W'(pin);
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_reading(pin[PIN_W-1:0]);
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic wait_drain();
        while (tracker.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; cfg_done lowers it.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_W'(data);
        @(posedge i_clk);
        tracker.set_reg(idx, CFG_W'(data));
        cfg_writes++;
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
    endtask

    // Register settings per phase: extremes first, then the usual set, then random.
    task automatic program_phase(int ph);
        int ofs, emp, ful, lo, rec;
        ofs = $urandom_range(0, CFG_MAX);
        emp = $urandom_range(0, 6000);
        ful = emp + $urandom_range(1, 2000);
        lo  = $urandom_range(emp, ful);
        rec = ($urandom_range(0, 7) == 0) ? lo - $urandom_range(0, lo < 200 ? lo : 200)
                                          : lo + $urandom_range(0, 300);
        if (rec > CFG_MAX) rec = CFG_MAX;
        case (ph)
            0: begin
                // Largest offset and widest span: readings saturate at the top.
                ofs = 1023; emp = 0; ful = CFG_MAX; lo = 0; rec = 0;
            end
            1: begin
                // Most negative offset, empty above full, and low above recovery.
                ofs = 1024; emp = CFG_MAX; ful = 0; lo = CFG_MAX; rec = 0;
            end
            2: begin
                ofs = OFFSET_RST; emp = EMPTY_RST; ful = FULL_RST;
                lo = LOW_RST; rec = RECOVER_RST;
            end
            3: begin
                // Empty equal to full, recovery just under the low threshold.
                emp = 4000; ful = 4000; lo = 3500; rec = 3400;
            end
            default: ;
        endcase
        cfg_write(CFG_OFFSET, ofs);
        cfg_write(CFG_EMPTY, emp);
        cfg_write(CFG_FULL, ful);
        cfg_write(CFG_LOW, lo);
        cfg_write(CFG_RECOVER, rec);
        if (ph == 1) cfg_write(CFG_UNUSED, $urandom_range(0, CFG_MAX));
        cfg_done();
    endtask

    // Stimulus: reset, directed readings, then phases of drifting battery voltage.
    initial begin
        int directed_pins [25] = '{0, 4095, 1, 2048, 1024,
                                   1400, 1400, 1400, 1400, 1400, 1400, 1400, 1400,
                                   1400, 1400, 1400, 1400, 1400, 1400, 1400,
                                   2100, 4095, 4095, 0, 1650};
        int walk, dir, pin, r, step, jitter;
        tracker = new();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, the window filling into low, then recovery.
        foreach (directed_pins[i]) send_reading(directed_pins[i]);
        stop_sending();
        wait_drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            program_phase(ph);
            quiet = (ph == 2) || ($urandom_range(0, 3) == 0);
            walk  = (int'(tracker.low_mv) - int'(tracker.offset_mv)) / 2;
            if (walk < 0) walk = 0;
            if (walk > PIN_MAX) walk = PIN_MAX;
            dir = 1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Now and then hold the sender until all results are back.
                if (k == PHASE_ITEMS / 2 && ph % 3 == 0) begin
                    stop_sending();
                    wait_drain();
                end
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    pin = $urandom_range(0, 1) ? PIN_MAX : 0;
                end else if (r < 10) begin
                    pin = $urandom_range(0, PIN_MAX);
                end else begin
                    if ($urandom_range(0, 19) == 0) dir = -dir;
                    step   = $urandom_range(0, 25);
                    jitter = $urandom_range(0, 16);
                    walk   = walk + dir * step + jitter - 8;
                    if (walk < 0) walk = 0;
                    if (walk > PIN_MAX) walk = PIN_MAX;
                    pin = walk;
                end
                send_reading(pin);
            end
            stop_sending();
            wait_drain();
        end

        $display("Run covered %0d readings and %0d checked results over %0d settings (%0d writes).",
                 tracker.readings, tracker.reports, NUM_PHASES + 1, cfg_writes);
        $display("Seen: %0d low entries, %0d recoveries, %0d redraws, %0d clamped samples.",
                 tracker.entries, tracker.exits, tracker.redraws, tracker.clamped);
        if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/blm_pkg.sv
hw/rtl/blm_cell.sv
hw/rtl/blm_div.sv
hw/rtl/battery_level_monitor_top.sv
tb/tb.sv
